/* hw/rtl/sot_pkg.sv */
`timescale 1ns / 1ps
// shared widths, saturation limits and the side-band word type for the sphere overlap test
// no dependencies

package sot_pkg;

    localparam int POS_W   = 32;            // signed centre coordinate
    localparam int SCALE_W = 31;            // unsigned scale component
    localparam int DIFF_W  = 33;            // centre difference and its magnitude
    localparam int ROOT_W  = 33;            // root width of every square-root pipe
    localparam int RAD_W   = 2 * ROOT_W;    // radicand width
    localparam int SSQ_W   = 2 * SCALE_W;   // square of one scale component

    localparam logic [DIFF_W-1:0] POS_LIMIT = DIFF_W'(33'h0_7FFF_FFFF);
    localparam logic [DIFF_W-1:0] NEG_LIMIT = DIFF_W'(33'h0_8000_0000);
    localparam logic [POS_W-1:0]  POS_SAT   = 32'h7FFF_FFFF;
    localparam logic [POS_W-1:0]  NEG_SAT   = 32'h8000_0000;

    // flags and depth that follow an item past the divider
    typedef struct packed {
        logic              hit;
        logic              zero;
        logic [2:0]        neg;
        logic [DIFF_W-1:0] pen;
    } t_side;

endpackage

/* hw/rtl/sot_delay.sv */
`timescale 1ns / 1ps
// fixed-length shift line for payload that runs beside the arithmetic pipes
// no dependencies

module sot_delay #(
    parameter int W = 8,
    parameter int D = 4
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_data,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_tap [0:D-1];

    always_ff @(posedge i_clk) begin
        r_tap[0] <= i_data;
        for (int k = 1; k < D; k++) begin
            r_tap[k] <= r_tap[k-1];
        end
    end

    assign o_data = r_tap[D-1];

endmodule

/* hw/rtl/sot_isqrt.sv */
`timescale 1ns / 1ps
// pipelined integer square root, one root bit per register stage
// depends on sot_pkg

module sot_isqrt #(
    parameter int RW = sot_pkg::ROOT_W
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [2*RW-1:0] i_rad,
    output logic            o_valid,
    output logic [RW-1:0]   o_root
);
    import sot_pkg::*;

    localparam int XW = 2 * RW + 2;

    logic [XW-1:0] r_rem  [1:RW];
    logic [RW-1:0] r_root [1:RW];
    logic          r_vld  [1:RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        localparam int B = RW - 1 - k;
        logic [XW-1:0] rem_src, trial;
        logic [RW-1:0] root_src;
        logic          vld_src, take;

        if (k == 0) begin : g_first
            assign rem_src  = XW'(i_rad);
            assign root_src = '0;
            assign vld_src  = i_valid;
        end else begin : g_next
            assign rem_src  = r_rem[k];
            assign root_src = r_root[k];
            assign vld_src  = r_vld[k];
        end

        // (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
        assign trial = (XW'(root_src) << (B + 1)) + (XW'(1) << (2 * B));
        assign take  = rem_src >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= vld_src;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k+1]  <= take ? rem_src - trial : rem_src;
            r_root[k+1] <= take ? root_src | (RW'(1) << B) : root_src;
        end
    end

    assign o_valid = r_vld[RW];
    assign o_root  = r_root[RW];

endmodule

/* hw/rtl/sot_div.sv */
`timescale 1ns / 1ps
// pipelined restoring divider for the unit direction, one quotient bit per stage
// depends on sot_pkg

module sot_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic [sot_pkg::DIFF_W+FRAC_BITS-1:0] i_num,
    input  logic [sot_pkg::DIFF_W-1:0]           i_den,
    output logic                                 o_valid,
    output logic [FRAC_BITS:0]                   o_quo
);
    import sot_pkg::*;

    localparam int NUM_W = DIFF_W + FRAC_BITS;
    localparam int Q_W   = FRAC_BITS + 1;
    localparam int XW    = NUM_W + 1;

    logic [XW-1:0]     r_rem [1:Q_W];
    logic [DIFF_W-1:0] r_den [1:Q_W];
    logic [Q_W-1:0]    r_quo [1:Q_W];
    logic              r_vld [1:Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        localparam int S = Q_W - 1 - k;
        logic [XW-1:0]     rem_src, trial;
        logic [DIFF_W-1:0] den_src;
        logic [Q_W-1:0]    quo_src;
        logic              vld_src, take;

        if (k == 0) begin : g_first
            assign rem_src = XW'(i_num);
            assign den_src = i_den;
            assign quo_src = '0;
            assign vld_src = i_valid;
        end else begin : g_next
            assign rem_src = r_rem[k];
            assign den_src = r_den[k];
            assign quo_src = r_quo[k];
            assign vld_src = r_vld[k];
        end

        assign trial = XW'(den_src) << S;
        assign take  = rem_src >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= vld_src;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= take ? rem_src - trial : rem_src;
            r_den[k+1] <= den_src;
            r_quo[k+1] <= take ? quo_src | (Q_W'(1) << S) : quo_src;
        end
    end

    assign o_valid = r_vld[Q_W];
    assign o_quo   = r_quo[Q_W];

endmodule

/* hw/rtl/sphere_overlap_test_core.sv */
`timescale 1ns / 1ps
// sphere against sphere overlap test with push-out vector, top level
// depends on sot_pkg, sot_delay, sot_isqrt, sot_div

// a word is taken on every cycle that start is high (busy is always low) and its result
// appears on the outputs with o_done high for a single cycle; the receiver cannot stall,
// so results must be taken as they come. each word passes through the 33-stage
// square-root pipes (centre distance and both radii run side by side) and the
// FRAC_BITS + 1 stage divider that forms the unit direction (FRAC_BITS is 16 at the
// default Q16.16). o_hit is high when the radius sum, each radius being half the length
// of its scale vector, reaches the centre distance; the push vector is the direction from
// source to target times the overlap depth, saturated to 32 bits, and zero on a miss
// or when the centres coincide

module sphere_overlap_test_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [sot_pkg::POS_W-1:0]   i_src_pos_x,
    input  logic signed [sot_pkg::POS_W-1:0]   i_src_pos_y,
    input  logic signed [sot_pkg::POS_W-1:0]   i_src_pos_z,
    input  logic        [sot_pkg::SCALE_W-1:0] i_src_scale_x,
    input  logic        [sot_pkg::SCALE_W-1:0] i_src_scale_y,
    input  logic        [sot_pkg::SCALE_W-1:0] i_src_scale_z,
    input  logic signed [sot_pkg::POS_W-1:0]   i_dst_pos_x,
    input  logic signed [sot_pkg::POS_W-1:0]   i_dst_pos_y,
    input  logic signed [sot_pkg::POS_W-1:0]   i_dst_pos_z,
    input  logic        [sot_pkg::SCALE_W-1:0] i_dst_scale_x,
    input  logic        [sot_pkg::SCALE_W-1:0] i_dst_scale_y,
    input  logic        [sot_pkg::SCALE_W-1:0] i_dst_scale_z,
    output logic                               o_done,
    output logic                               o_hit,
    output logic signed [sot_pkg::POS_W-1:0]   o_push_x,
    output logic signed [sot_pkg::POS_W-1:0]   o_push_y,
    output logic signed [sot_pkg::POS_W-1:0]   o_push_z
);
    import sot_pkg::*;

    localparam int NUM_W  = DIFF_W + FRAC_BITS;
    localparam int Q_W    = FRAC_BITS + 1;
    localparam int PROD_W = Q_W + DIFF_W;
    localparam int SIDE_W = $bits(t_side);
    localparam int D1_W   = 3 * DIFF_W + 3;

    // fully pipelined, never holds off a word
    assign busy = 1'b0;

    logic accept;
    assign accept = start & ~busy;

    // gather the axes so every stage can loop over them
    logic signed [POS_W-1:0] src_pos [3];
    logic signed [POS_W-1:0] dst_pos [3];
    logic [SCALE_W-1:0]      src_sc  [3];
    logic [SCALE_W-1:0]      dst_sc  [3];

    assign src_pos[0] = i_src_pos_x;
    assign src_pos[1] = i_src_pos_y;
    assign src_pos[2] = i_src_pos_z;
    assign dst_pos[0] = i_dst_pos_x;
    assign dst_pos[1] = i_dst_pos_y;
    assign dst_pos[2] = i_dst_pos_z;
    assign src_sc[0]  = i_src_scale_x;
    assign src_sc[1]  = i_src_scale_y;
    assign src_sc[2]  = i_src_scale_z;
    assign dst_sc[0]  = i_dst_scale_x;
    assign dst_sc[1]  = i_dst_scale_y;
    assign dst_sc[2]  = i_dst_scale_z;

    // stage 1: centre difference, target minus source, held exactly in 33 bits
    logic                     r1_vld;
    logic signed [DIFF_W-1:0] r1_diff   [3];
    logic [SCALE_W-1:0]       r1_src_sc [3];
    logic [SCALE_W-1:0]       r1_dst_sc [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r1_diff[a]   <= DIFF_W'(dst_pos[a]) - DIFF_W'(src_pos[a]);
            r1_src_sc[a] <= src_sc[a];
            r1_dst_sc[a] <= dst_sc[a];
        end
    end

    // stage 2: magnitudes and squares
    logic              r2_vld;
    logic [DIFF_W-1:0] r2_mag  [3];
    logic              r2_neg  [3];
    logic [RAD_W-1:0]  r2_dsq  [3];
    logic [SSQ_W-1:0]  r2_ssq  [3];
    logic [SSQ_W-1:0]  r2_tsq  [3];
    logic [DIFF_W-1:0] n_mag   [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_mag[a] = r1_diff[a][DIFF_W-1] ? $unsigned(-r1_diff[a]) : $unsigned(r1_diff[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r2_mag[a] <= n_mag[a];
            r2_neg[a] <= r1_diff[a][DIFF_W-1];
            r2_dsq[a] <= RAD_W'(n_mag[a]) * RAD_W'(n_mag[a]);
            r2_ssq[a] <= SSQ_W'(r1_src_sc[a]) * SSQ_W'(r1_src_sc[a]);
            r2_tsq[a] <= SSQ_W'(r1_dst_sc[a]) * SSQ_W'(r1_dst_sc[a]);
        end
    end

    // stage 3: sums of squares, none of them can overflow its radicand
    logic              r3_vld;
    logic [RAD_W-1:0]  r3_drad, r3_srad, r3_trad;
    logic [DIFF_W-1:0] r3_mag [3];
    logic              r3_neg [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_drad <= r2_dsq[0] + r2_dsq[1] + r2_dsq[2];
        r3_srad <= RAD_W'(r2_ssq[0]) + RAD_W'(r2_ssq[1]) + RAD_W'(r2_ssq[2]);
        r3_trad <= RAD_W'(r2_tsq[0]) + RAD_W'(r2_tsq[1]) + RAD_W'(r2_tsq[2]);
        for (int a = 0; a < 3; a++) begin
            r3_mag[a] <= r2_mag[a];
            r3_neg[a] <= r2_neg[a];
        end
    end

    // three root pipes of equal length so the results line up
    logic              sq_vld;
    logic [ROOT_W-1:0] ctr_dist, src_root, dst_root;

    sot_isqrt #(.RW(ROOT_W)) u_dist_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r3_vld),
        .i_rad   (r3_drad),
        .o_valid (sq_vld),
        .o_root  (ctr_dist)
    );

    sot_isqrt #(.RW(ROOT_W)) u_src_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r3_vld),
        .i_rad   (r3_srad),
        .o_valid (),
        .o_root  (src_root)
    );

    sot_isqrt #(.RW(ROOT_W)) u_dst_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r3_vld),
        .i_rad   (r3_trad),
        .o_valid (),
        .o_root  (dst_root)
    );

    // magnitudes and signs ride beside the root pipes
    logic [D1_W-1:0]   d1_in, d1_out;
    logic [DIFF_W-1:0] sq_mag [3];
    logic [2:0]        sq_neg;

    assign d1_in = {r3_mag[2], r3_mag[1], r3_mag[0], r3_neg[2], r3_neg[1], r3_neg[0]};
    assign {sq_mag[2], sq_mag[1], sq_mag[0], sq_neg} = d1_out;

    sot_delay #(.W(D1_W), .D(ROOT_W)) u_root_side (
        .i_clk  (i_clk),
        .i_data (d1_in),
        .o_data (d1_out)
    );

    // stage 4: radius sum, hit decision and overlap depth
    logic              r4_vld;
    t_side             r4_side;
    logic [DIFF_W-1:0] r4_dist;
    logic [DIFF_W-1:0] r4_mag [3];
    logic [DIFF_W-1:0] total;

    // each radius is half its root
    assign total = DIFF_W'(src_root >> 1) + DIFF_W'(dst_root >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_side.hit  <= total >= ctr_dist;
        r4_side.zero <= ctr_dist == '0;
        r4_side.neg  <= sq_neg;
        r4_side.pen  <= total - ctr_dist;
        r4_dist      <= ctr_dist;
        for (int a = 0; a < 3; a++) begin
            r4_mag[a] <= sq_mag[a];
        end
    end

    // unit direction per axis, |d| scaled up and divided by the distance
    logic           dv_vld;
    logic [Q_W-1:0] unit [3];

    for (genvar a = 0; a < 3; a++) begin : g_div
        logic vld_out;

        sot_div #(.FRAC_BITS(FRAC_BITS)) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (r4_vld),
            .i_num   (NUM_W'(r4_mag[a]) << FRAC_BITS),
            .i_den   (r4_dist),
            .o_valid (vld_out),
            .o_quo   (unit[a])
        );

        if (a == 0) begin : g_vld
            assign dv_vld = vld_out;
        end
    end

    t_side             dv_side;
    logic [SIDE_W-1:0] d2_out;

    assign dv_side = t_side'(d2_out);

    sot_delay #(.W(SIDE_W), .D(Q_W)) u_div_side (
        .i_clk  (i_clk),
        .i_data (SIDE_W'(r4_side)),
        .o_data (d2_out)
    );

    // stage 5: scale the direction by the depth, drop the fraction
    logic              r5_vld;
    t_side             r5_side;
    logic [DIFF_W-1:0] r5_mag [3];
    logic [PROD_W-1:0] prod   [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            prod[a] = PROD_W'(unit[a]) * PROD_W'(dv_side.pen);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_side <= dv_side;
        for (int a = 0; a < 3; a++) begin
            // the magnitude never exceeds the depth, so 33 bits hold it
            r5_mag[a] <= prod[a][FRAC_BITS +: DIFF_W];
        end
    end

    // stage 6: sign, saturation and the miss or coincident-centre clear
    logic [POS_W-1:0] n_push [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            if (!r5_side.hit || r5_side.zero) begin
                n_push[a] = '0;
            end else if (r5_side.neg[a]) begin
                n_push[a] = (r5_mag[a] > NEG_LIMIT) ? NEG_SAT : POS_W'(-r5_mag[a]);
            end else begin
                n_push[a] = (r5_mag[a] > POS_LIMIT) ? POS_SAT : POS_W'(r5_mag[a]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        o_hit    <= r5_side.hit;
        o_push_x <= $signed(n_push[0]);
        o_push_y <= $signed(n_push[1]);
        o_push_z <= $signed(n_push[2]);
    end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// self-checking testbench for sphere_overlap_test_core: directed and random pair tests
// depends on sot_pkg and sphere_overlap_test_core

module tb;
    import sot_pkg::*;

    localparam int FRAC      = 16;
    localparam int LATENCY   = FRAC + 40;
    localparam int CYCLE_CAP = 400000;

    typedef struct {
        logic             hit;
        logic [POS_W-1:0] px;
        logic [POS_W-1:0] py;
        logic [POS_W-1:0] pz;
    } t_push_word;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic signed [POS_W-1:0] sp_x, sp_y, sp_z, dp_x, dp_y, dp_z;
    logic [SCALE_W-1:0] ss_x, ss_y, ss_z, ds_x, ds_y, ds_z;
    logic o_done, o_hit;
    logic signed [POS_W-1:0] o_push_x, o_push_y, o_push_z;

    t_push_word push_q[$];
    int mismatches;
    int cycles;
    bit bursts_on;

    sphere_overlap_test_core #(.FRAC_BITS(FRAC)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_src_pos_x(sp_x), .i_src_pos_y(sp_y), .i_src_pos_z(sp_z),
        .i_src_scale_x(ss_x), .i_src_scale_y(ss_y), .i_src_scale_z(ss_z),
        .i_dst_pos_x(dp_x), .i_dst_pos_y(dp_y), .i_dst_pos_z(dp_z),
        .i_dst_scale_x(ds_x), .i_dst_scale_y(ds_y), .i_dst_scale_z(ds_z),
        .o_done(o_done), .o_hit(o_hit),
        .o_push_x(o_push_x), .o_push_y(o_push_y), .o_push_z(o_push_z)
    );

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // exact integer square root, floor
    function automatic logic [65:0] floor_root(logic [131:0] v);
        logic [65:0] r;
        logic [65:0] c;
        r = '0;
        for (int b = 65; b >= 0; b--) begin
            c = r | (66'd1 << b);
            if ({66'd0, c} * {66'd0, c} <= v) r = c;
        end
        return r;
    endfunction

    function automatic logic [65:0] radius(logic [SCALE_W-1:0] a, logic [SCALE_W-1:0] b,
                                           logic [SCALE_W-1:0] c);
        logic [131:0] s;
        s = {101'd0, a} * {101'd0, a} + {101'd0, b} * {101'd0, b}
            + {101'd0, c} * {101'd0, c};
        return floor_root(s) >> 1;
    endfunction

    // one axis of the push vector, saturated
    function automatic logic [POS_W-1:0] push_axis(logic signed [33:0] d, logic [65:0] cdist,
                                                   logic [65:0] pen);
        logic [131:0] mag;
        logic [131:0] u;
        logic [33:0] ad;
        ad  = d[33] ? -d : d;
        u   = ({98'd0, ad} << FRAC) / {66'd0, cdist};
        mag = (u * {66'd0, pen}) >> FRAC;
        if (d[33]) begin
            if (mag > 132'h8000_0000) mag = 132'h8000_0000;
            return POS_W'(-mag);
        end
        if (mag > 132'h7FFF_FFFF) mag = 132'h7FFF_FFFF;
        return POS_W'(mag);
    endfunction

    function automatic t_push_word predict_overlap(
        logic signed [POS_W-1:0] ax, ay, az, bx, by, bz,
        logic [SCALE_W-1:0] sx, sy, sz, tx, ty, tz);
        t_push_word w;
        logic signed [33:0] d [3];
        logic [131:0] ssq;
        logic [65:0] cdist, total;
        logic [33:0] ad;
        d[0] = 34'(bx) - 34'(ax);
        d[1] = 34'(by) - 34'(ay);
        d[2] = 34'(bz) - 34'(az);
        ssq = '0;
        for (int i = 0; i < 3; i++) begin
            ad  = d[i][33] ? -d[i] : d[i];
            ssq = ssq + {98'd0, ad} * {98'd0, ad};
        end
        cdist = floor_root(ssq);
        total = radius(sx, sy, sz) + radius(tx, ty, tz);
        w = '{hit: 1'b0, px: '0, py: '0, pz: '0};
        if (total >= cdist) begin
            w.hit = 1'b1;
            if (cdist != 0) begin
                w.px = push_axis(d[0], cdist, total - cdist);
                w.py = push_axis(d[1], cdist, total - cdist);
                w.pz = push_axis(d[2], cdist, total - cdist);
            end
        end
        return w;
    endfunction

    task automatic idle_burst();
        if (bursts_on && $urandom_range(0, 7) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    // send one word and hold the expected result; start stays high across back-to-back words
    task automatic send_pair(logic signed [POS_W-1:0] ax, ay, az, bx, by, bz,
                             logic [SCALE_W-1:0] sx, sy, sz, tx, ty, tz);
        sp_x <= ax; sp_y <= ay; sp_z <= az;
        dp_x <= bx; dp_y <= by; dp_z <= bz;
        ss_x <= sx; ss_y <= sy; ss_z <= sz;
        ds_x <= tx; ds_y <= ty; ds_z <= tz;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        push_q.push_back(predict_overlap(ax, ay, az, bx, by, bz, sx, sy, sz, tx, ty, tz));
        if (bursts_on && $urandom_range(0, 7) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    task automatic stop_sending();
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [SCALE_W-1:0] rand_scale(int shift);
        return SCALE_W'($urandom) >> shift;
    endfunction

    task automatic test_extremes();
        logic signed [POS_W-1:0] mx, mn;
        logic [SCALE_W-1:0] sm;
        mx = 32'sh7FFF_FFFF; mn = 32'sh8000_0000; sm = '1;
        // coincident centres, zero and full scales
        send_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_pair(mx, mn, mx, mx, mn, mx, sm, sm, sm, sm, sm, sm);
        // widest separation, both directions
        send_pair(mn, mn, mn, mx, mx, mx, sm, sm, sm, sm, sm, sm);
        send_pair(mx, mx, mx, mn, mn, mn, sm, sm, sm, sm, sm, sm);
        send_pair(mn, mn, mn, mx, mx, mx, 0, 0, 0, 0, 0, 0);
        // oversized push saturates
        send_pair(0, 0, 0, 1, 0, 0, sm, sm, sm, sm, sm, sm);
        send_pair(0, 0, 0, -1, -1, -1, sm, sm, sm, sm, sm, sm);
        // just touching: radii 1 + 1 at distance 2, then distance 3 misses
        send_pair(0, 0, 0, 2, 0, 0, 2, 0, 0, 2, 0, 0);
        send_pair(0, 0, 0, 0, 3, 0, 2, 0, 0, 2, 0, 0);
        // ordinary overlap and miss in Q16.16
        send_pair(32'sh0001_0000, 0, 0, 32'sh0002_0000, 32'sh0000_8000, 0,
                  31'h0002_0000, 0, 0, 31'h0002_0000, 0, 0);
        send_pair(0, 0, 0, 32'sh0010_0000, 0, 0, 31'h0001_0000, 0, 0, 31'h0001_0000, 0, 0);
        send_pair(-5, 7, -9, 3, -4, 6, 31'd100, 31'd50, 31'd25, 31'd10, 31'd20, 31'd30);
        stop_sending();
    endtask

    task automatic test_random(int count, bit with_bursts);
        logic signed [POS_W-1:0] ax, ay, az;
        logic [SCALE_W-1:0] sx, sy, sz, tx, ty, tz;
        int sh, span;
        bursts_on = with_bursts;
        for (int n = 0; n < count; n++) begin
            idle_burst();
            ax = $urandom; ay = $urandom; az = $urandom;
            sh = $urandom_range(0, 30);
            sx = rand_scale(sh); sy = rand_scale(sh); sz = rand_scale(sh);
            tx = rand_scale(sh); ty = rand_scale(sh); tz = rand_scale(sh);
            if ($urandom_range(0, 4) == 0) begin
                // fully random pair, mostly misses
                send_pair(ax, ay, az, $urandom, $urandom, $urandom, sx, sy, sz, tx, ty, tz);
            end else begin
                // target near the source, scaled to the radii so hits and misses mix
                span = (sh > 29) ? 1 : (1 << (30 - sh));
                send_pair(ax, ay, az,
                          ax + $signed($urandom_range(0, 2 * span)) - span,
                          ay + $signed($urandom_range(0, 2 * span)) - span,
                          az + $signed($urandom_range(0, 2 * span)) - span,
                          sx, sy, sz, tx, ty, tz);
            end
        end
        stop_sending();
    endtask

    task automatic drain_results();
        while (push_q.size() != 0) @(posedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_push_word w;
        if (i_rst_n && o_done) begin
            if (push_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("tb: result with no word pending");
            end else begin
                w = push_q.pop_front();
                if (o_hit !== w.hit || o_push_x !== w.px || o_push_y !== w.py
                    || o_push_z !== w.pz) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("tb: mismatch exp hit %0b push %h %h %h got %0b %h %h %h",
                                 w.hit, w.px, w.py, w.pz, o_hit, o_push_x, o_push_y,
                                 o_push_z);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial begin
        mismatches = 0; cycles = 0; bursts_on = 1'b0;
        i_rst_n = 1'b0; start = 1'b0;
        sp_x = '0; sp_y = '0; sp_z = '0; dp_x = '0; dp_y = '0; dp_z = '0;
        ss_x = '0; ss_y = '0; ss_z = '0; ds_x = '0; ds_y = '0; ds_z = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_random(800, 1'b1);
        // sender holds off until the pipe is empty
        drain_results();
        test_random(600, 1'b1);
        test_random(300, 1'b0);
        drain_results();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatches == 0 && push_q.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule

/* filelist.f */
hw/rtl/sot_pkg.sv
hw/rtl/sot_delay.sv
hw/rtl/sot_isqrt.sv
hw/rtl/sot_div.sv
hw/rtl/sphere_overlap_test_core.sv
test/tb.sv
